>>> sv/rbsi_pkg.sv
// shared constants for the ray/box slab intersection core
// no dependencies
`default_nettype none
package rbsi_pkg;
	localparam int FRAC_BITS_DEF = 16;
	// quotient bits produced by the divider lanes, and divisor width
	localparam int QB = 33;
	localparam int DW = 33;
	// divider depth: load stage, one stage per quotient bit, saturation stage
	localparam int DIV_LAT = QB + 2;
	localparam logic [30:0] EPS_RESET = 31'd66;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	// register index taken from paddr[2]
	localparam logic REG_EPS = 1'b0;
endpackage
`default_nettype wire

>>> sv/rbsi_div.sv
// pipelined restoring divider lane, one quotient bit per stage, saturated to s32
// depends on rbsi_pkg
`default_nettype none
module rbsi_div import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [QB+FRAC_BITS-1:0] num,
	input  wire logic [DW-1:0]          den,
	input  wire logic                   neg,
	output logic signed [31:0]          quot
);
	localparam int NW = QB + FRAC_BITS;

	logic [DW-1:0] rem_s [0:QB];
	logic [QB-1:0] low_s [0:QB];
	logic [QB-1:0] q_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic          ovf_s [0:QB];
	logic          neg_s [0:QB];

	// quotient does not fit in QB bits when the upper numerator part reaches den
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(num[NW-1:QB]);
			low_s[0] <= num[QB-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den;
			ovf_s[0] <= DW'(num[NW-1:QB]) >= den;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [DW:0] trial;
		logic        take;
		assign trial = {rem_s[k-1], low_s[k-1][QB-k]};
		assign take  = trial >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? DW'(trial - {1'b0, den_s[k-1]}) : trial[DW-1:0];
				low_s[k] <= low_s[k-1];
				q_s[k]   <= {q_s[k-1][QB-2:0], take};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	logic [QB-1:0] qm;
	assign qm = q_s[QB];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s[QB]) begin
				if (ovf_s[QB] || qm[QB-1:31] != '0) begin
					quot <= S32_MAX;
				end else begin
					quot <= $signed(qm[31:0]);
				end
			end else begin
				if (ovf_s[QB] || qm > QB'(33'h0_8000_0000)) begin
					quot <= S32_MIN;
				end else begin
					quot <= $signed(-qm[31:0]);
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/ray_box_slab_intersect_core.sv
// ray segment versus axis-aligned box slab test, signed fixed point
// input transaction passes stage 1, the divider lanes and p1 to p4 into the result register
// throughput one transaction per cycle while the result register is not stalled, set by the six pipelined divider lanes
// a stalled result register holds the pipe only when its last stage is full
// arst_n clears valid bits and resets parallel_epsilon to 66; data is not reset
`default_nettype none
module ray_box_slab_intersect_core import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] start_x,
	input  wire logic signed [31:0] start_y,
	input  wire logic signed [31:0] start_z,
	input  wire logic signed [31:0] end_x,
	input  wire logic signed [31:0] end_y,
	input  wire logic signed [31:0] end_z,
	input  wire logic signed [31:0] box_min_x,
	input  wire logic signed [31:0] box_min_y,
	input  wire logic signed [31:0] box_min_z,
	input  wire logic signed [31:0] box_max_x,
	input  wire logic signed [31:0] box_max_y,
	input  wire logic signed [31:0] box_max_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic signed [31:0]      hit_x,
	output logic signed [31:0]      hit_y,
	output logic signed [31:0]      hit_z,
	output logic signed [31:0]      entry_time
);
	localparam int NW = QB + FRAC_BITS;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic [64:0] RND = 65'((65'd1 << FRAC_BITS) - 65'd1);

	typedef struct packed {
		logic [2:0][31:0] s;
		logic [2:0][32:0] d;
		logic [2:0]       par;
		logic             ok;
	} side_t;

	// configuration
	logic [30:0] eps_q;
	logic        wr;
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (wr && paddr[2] == REG_EPS) begin
			eps_q <= pwdata[30:0];
		end
	end
	assign prdata = (paddr[2] == REG_EPS) ? {1'b0, eps_q} : '0;

	// pipeline control
	logic en;
	logic v_s1, v_p1, v_p2, v_p3, v_p4, out_valid_q;
	logic [DIV_LAT:1] vd_q;
	assign en       = !v_p4 || !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vd_q <= '0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_p4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			vd_q <= {vd_q[DIV_LAT-1:1], v_s1};
			v_p1 <= vd_q[DIV_LAT];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
		end
	end

	// stage 1: direction, parallel test, slab numerators
	logic signed [31:0] sa [3];
	logic signed [31:0] ea [3];
	logic signed [31:0] la [3];
	logic signed [31:0] ha [3];
	assign sa = '{start_x, start_y, start_z};
	assign ea = '{end_x, end_y, end_z};
	assign la = '{box_min_x, box_min_y, box_min_z};
	assign ha = '{box_max_x, box_max_y, box_max_z};

	side_t            side_s1;
	logic [2:0]       neg_lo_s1, neg_hi_s1;
	logic [NW-1:0]    num_lo_s1 [3];
	logic [NW-1:0]    num_hi_s1 [3];
	logic [DW-1:0]    dmag_s1 [3];

	logic signed [32:0] d_c [3];
	logic [32:0]        dm_c [3];
	logic [32:0]        nlm_c [3];
	logic [32:0]        nhm_c [3];
	logic [2:0]         par_c, in_slab_c, neg_lo_c, neg_hi_c;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [32:0] nl, nh;
		assign d_c[a] = 33'(ea[a]) - 33'(sa[a]);
		assign nl = 33'(la[a]) - 33'(sa[a]);
		assign nh = 33'(ha[a]) - 33'(sa[a]);
		assign dm_c[a]  = d_c[a][32] ? 33'(-d_c[a]) : 33'(d_c[a]);
		assign nlm_c[a] = nl[32] ? 33'(-nl) : 33'(nl);
		assign nhm_c[a] = nh[32] ? 33'(-nh) : 33'(nh);
		assign par_c[a] = (d_c[a] == '0) || (dm_c[a] < {2'b00, eps_q});
		assign in_slab_c[a] = (sa[a] >= la[a]) && (sa[a] <= ha[a]);
		assign neg_lo_c[a] = nl[32] ^ d_c[a][32];
		assign neg_hi_c[a] = nh[32] ^ d_c[a][32];
	end

	// a parallel axis misses unless the start lies inside its slab
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				side_s1.s[a] <= sa[a];
				side_s1.d[a] <= d_c[a];
				dmag_s1[a]   <= dm_c[a];
				num_lo_s1[a] <= {nlm_c[a], FRAC_BITS'(0)};
				num_hi_s1[a] <= {nhm_c[a], FRAC_BITS'(0)};
			end
			side_s1.par <= par_c;
			side_s1.ok  <= (in_slab_c | ~par_c) == 3'b111;
			neg_lo_s1   <= neg_lo_c;
			neg_hi_s1   <= neg_hi_c;
		end
	end

	// divider lanes and matching sideband delay
	logic signed [31:0] t_lo [3];
	logic signed [31:0] t_hi [3];
	for (genvar a = 0; a < 3; a++) begin : g_div
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
			.clk (clk), .en (en), .num (num_lo_s1[a]), .den (dmag_s1[a]),
			.neg (neg_lo_s1[a]), .quot (t_lo[a])
		);
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
			.clk (clk), .en (en), .num (num_hi_s1[a]), .den (dmag_s1[a]),
			.neg (neg_hi_s1[a]), .quot (t_hi[a])
		);
	end

	side_t side_sd [1:DIV_LAT];
	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[1] <= side_s1;
			for (int k = 2; k <= DIV_LAT; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
		end
	end

	// p1: order entry and exit per axis, parallel axes take the full range
	side_t              side_p1;
	logic signed [31:0] lo_p1 [3];
	logic signed [31:0] hi_p1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			side_p1 <= side_sd[DIV_LAT];
			for (int a = 0; a < 3; a++) begin
				if (side_sd[DIV_LAT].par[a]) begin
					lo_p1[a] <= S32_MIN;
					hi_p1[a] <= S32_MAX;
				end else if (t_lo[a] > t_hi[a]) begin
					lo_p1[a] <= t_hi[a];
					hi_p1[a] <= t_lo[a];
				end else begin
					lo_p1[a] <= t_lo[a];
					hi_p1[a] <= t_hi[a];
				end
			end
		end
	end

	// p2: interval intersection
	logic signed [31:0] mx01, mn01;
	assign mx01 = (lo_p1[0] > lo_p1[1]) ? lo_p1[0] : lo_p1[1];
	assign mn01 = (hi_p1[0] < hi_p1[1]) ? hi_p1[0] : hi_p1[1];
	side_t              side_p2;
	logic signed [31:0] tmin_p2, tmax_p2;
	always_ff @(posedge clk) begin
		if (en) begin
			side_p2 <= side_p1;
			tmin_p2 <= (mx01 > lo_p1[2]) ? mx01 : lo_p1[2];
			tmax_p2 <= (mn01 < hi_p1[2]) ? mn01 : hi_p1[2];
		end
	end

	// p3: final hit decision, scaled direction products
	logic               hit_p3;
	logic signed [31:0] tmin_p3;
	logic [2:0][31:0]   s_p3;
	logic signed [64:0] prod_p3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			hit_p3  <= side_p2.ok && (tmin_p2 <= tmax_p2) && (tmin_p2 <= ONE)
				&& (tmax_p2 >= 32'sd0);
			tmin_p3 <= tmin_p2;
			s_p3    <= side_p2.s;
			for (int a = 0; a < 3; a++) begin
				prod_p3[a] <= 65'($signed(side_p2.d[a])) * 65'(tmin_p2);
			end
		end
	end

	// p4: divide by 2^FRAC_BITS truncating toward zero
	logic               hit_p4;
	logic signed [31:0] tmin_p4;
	logic [2:0][31:0]   s_p4;
	logic signed [64:0] off_p4 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			hit_p4  <= hit_p3;
			tmin_p4 <= tmin_p3;
			s_p4    <= s_p3;
			for (int a = 0; a < 3; a++) begin
				off_p4[a] <= (prod_p3[a] + (prod_p3[a][64] ? $signed(RND) : 65'sd0))
					>>> FRAC_BITS;
			end
		end
	end

	// result register: add start, saturate, zero the point and entry time on a miss
	logic signed [31:0] pt [3];
	for (genvar a = 0; a < 3; a++) begin : g_pt
		logic signed [65:0] sum;
		assign sum = 66'($signed(s_p4[a])) + 66'(off_p4[a]);
		assign pt[a] = (sum > 66'(S32_MAX)) ? S32_MAX :
			(sum < 66'(S32_MIN)) ? S32_MIN : sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= v_p4;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			hit        <= hit_p4;
			hit_x      <= hit_p4 ? pt[0] : '0;
			hit_y      <= hit_p4 ? pt[1] : '0;
			hit_z      <= hit_p4 ? pt[2] : '0;
			entry_time <= hit_p4 ? tmin_p4 : '0;
		end
	end
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire
